// File: src/cal_pkg.sv
// shared types and codes for the cursor array list
package cal_pkg;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_FIRST  = 2'd1;
    localparam logic [1:0] OP_NEXT   = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOREAD   = 2'd2;
    localparam logic [1:0] ST_NOREMOVE = 2'd3;

    // input item
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value_in;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [7:0]         count;
        logic signed [7:0]  cursor;
    } t_out_item;

    // per-cycle command broadcast along the cell row
    typedef struct packed {
        logic wr;
        logic shift;
    } t_cell_cmd;

endpackage

// File: src/cal_cell.sv
// one storage cell of the list row, holding a single entry
module cal_cell #(
    parameter int unsigned AW  = 7,
    parameter int unsigned CW  = 8,
    parameter int unsigned IDX = 0
) (
    input  logic                i_clk,
    input  cal_pkg::t_cell_cmd  i_cmd,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [AW-1:0]       i_lo,
    input  logic [CW-1:0]       i_cnt,
    input  logic [AW-1:0]       i_sel,
    input  logic signed [31:0]  i_value,
    input  logic signed [31:0]  i_next,
    output logic signed [31:0]  o_data,
    output logic signed [31:0]  o_tap
);

    localparam logic [AW-1:0] L_ADDR = AW'(IDX);
    localparam logic [CW-1:0] L_POS  = CW'(IDX);
    localparam logic [CW-1:0] L_POS1 = CW'(IDX + 1);

    logic signed [31:0] r_data;
    logic               w_wr_here;
    logic               w_shift_here;

    // this cell is the tail slot, or lies in the band that moves down
    assign w_wr_here    = i_cmd.wr && (i_wr_addr == L_ADDR);
    assign w_shift_here = i_cmd.shift && (L_POS >= {1'b0, i_lo}) && (L_POS1 < i_cnt);

    // entry storage, takes the neighbour's word on a shift
    always_ff @(posedge i_clk) begin
        if (w_wr_here) begin
            r_data <= i_value;
        end else if (w_shift_here) begin
            r_data <= i_next;
        end
    end

    // drive the read tap only when selected
    assign o_tap  = (i_sel == L_ADDR) ? r_data : '0;
    assign o_data = r_data;

endmodule

// File: src/cursor_array_list_core.sv
// top level of the cursor array list: control, cell row and result register
//
//  channel   direction  payload                 handshake
//  input     in         i_item (t_in_item)      i_valid / o_stall
//  result    out        o_item (t_out_item)     o_valid / i_stall
//
// each item goes through accept, cell read through the tap OR tree,
// then commit of the cell command and the result register
// the commit waits while the result register holds an item not yet taken
// reset clears the count to zero and the cursor to minus one; entries are
// left unset and only entries below the count are ever read
// a new item is taken while an earlier result still waits downstream
module cursor_array_list_core #(
    parameter int unsigned DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  cal_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output cal_pkg::t_out_item o_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = AW + 1;
    localparam logic [CW-1:0] L_FULL = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state                    r_state, n_state;
    logic [1:0]                r_op;
    logic signed [31:0]        r_val;
    logic [AW-1:0]             r_addr;
    logic signed [31:0]        r_rd;
    logic [CW-1:0]             r_count, n_count;
    logic signed [CW-1:0]      r_cursor, n_cursor;
    logic                      r_out_valid;
    cal_pkg::t_out_item        r_out, n_out;

    logic                      w_accept;
    logic                      w_slot;
    logic                      w_commit;
    logic [CW-1:0]             w_cur_inc;
    logic                      w_full;
    logic                      w_next_ok;
    logic                      w_rm_ok;
    logic [AW-1:0]             w_rd_addr;
    logic signed [31:0]        w_tap_or;
    cal_pkg::t_cell_cmd        w_cmd;
    logic [1:0]                w_status;
    logic signed [31:0]        w_value;
    logic [31:0]               w_cnt_ext;
    logic signed [31:0]        w_cur_ext;
    logic signed [31:0]        w_data [DEPTH];
    logic signed [31:0]        w_tap  [DEPTH];

    // handshake
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_slot   = !r_out_valid || !i_stall;
    assign w_commit = (r_state == S_EXEC) && w_slot;

    // cursor and count checks
    assign w_cur_inc = $unsigned(r_cursor) + CW'(1);
    assign w_full    = (r_count == L_FULL);
    assign w_next_ok = (w_cur_inc < r_count);
    assign w_rm_ok   = (r_count != '0) && !r_cursor[CW-1]
                       && ($unsigned(r_cursor) < r_count);

    // address of the entry to read for this item
    always_comb begin
        unique case (i_item.op)
            cal_pkg::OP_FIRST:  w_rd_addr = '0;
            cal_pkg::OP_NEXT:   w_rd_addr = w_cur_inc[AW-1:0];
            cal_pkg::OP_REMOVE: w_rd_addr = r_cursor[AW-1:0];
            default:            w_rd_addr = '0;
        endcase
    end

    // state sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // operation decode at commit
    always_comb begin
        w_cmd    = '0;
        w_status = cal_pkg::ST_OK;
        w_value  = '0;
        n_count  = r_count;
        n_cursor = r_cursor;
        unique case (r_op)
            cal_pkg::OP_APPEND: begin
                if (w_full) begin
                    w_status = cal_pkg::ST_FULL;
                end else begin
                    w_cmd.wr = w_commit;
                    n_count  = r_count + CW'(1);
                end
            end
            cal_pkg::OP_FIRST: begin
                if (r_count != '0) begin
                    n_cursor = '0;
                    w_value  = r_rd;
                end else begin
                    w_status = cal_pkg::ST_NOREAD;
                end
            end
            cal_pkg::OP_NEXT: begin
                if (w_next_ok) begin
                    n_cursor = $signed(w_cur_inc);
                    w_value  = r_rd;
                end else begin
                    w_status = cal_pkg::ST_NOREAD;
                end
            end
            default: begin
                if (w_rm_ok) begin
                    w_cmd.shift = w_commit;
                    w_value     = r_rd;
                    n_count     = r_count - CW'(1);
                    n_cursor    = r_cursor - CW'(1);
                end else begin
                    w_status = cal_pkg::ST_NOREMOVE;
                end
            end
        endcase
    end

    // result fields reported in eight bits
    assign w_cnt_ext = 32'(n_count);
    assign w_cur_ext = 32'(n_cursor);

    always_comb begin
        n_out.status    = w_status;
        n_out.value_out = w_value;
        n_out.count     = w_cnt_ext[7:0];
        n_out.cursor    = w_cur_ext[7:0];
    end

    // row of cells, each fed by its upper neighbour; the last cell feeds itself
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g + 1 < DEPTH) begin : g_mid
            cal_cell #(.AW(AW), .CW(CW), .IDX(g)) u_cell (
                .i_clk    (i_clk),
                .i_cmd    (w_cmd),
                .i_wr_addr(r_count[AW-1:0]),
                .i_lo     (r_cursor[AW-1:0]),
                .i_cnt    (r_count),
                .i_sel    (r_addr),
                .i_value  (r_val),
                .i_next   (w_data[g+1]),
                .o_data   (w_data[g]),
                .o_tap    (w_tap[g])
            );
        end else begin : g_end
            cal_cell #(.AW(AW), .CW(CW), .IDX(g)) u_cell (
                .i_clk    (i_clk),
                .i_cmd    (w_cmd),
                .i_wr_addr(r_count[AW-1:0]),
                .i_lo     (r_cursor[AW-1:0]),
                .i_cnt    (r_count),
                .i_sel    (r_addr),
                .i_value  (r_val),
                .i_next   (w_data[g]),
                .o_data   (w_data[g]),
                .o_tap    (w_tap[g])
            );
        end
    end

    // merge of the cell taps, only the selected one can be non-zero
    always_comb begin
        w_tap_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_tap_or = w_tap_or | w_tap[k];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count     <= n_count;
                r_cursor    <= n_cursor;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_item.op;
            r_val  <= i_item.value_in;
            r_addr <= w_rd_addr;
        end
        if (r_state == S_READ) begin
            r_rd <= w_tap_or;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// File: src/cal_checker.sv
// port-level checks for the cursor array list, bound to the top level
module cal_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input cal_pkg::t_in_item  i_item,
    input logic               o_valid,
    input logic               i_stall,
    input cal_pkg::t_out_item o_item
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result item changed while stalled");

    // refused operations carry a zero word
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.status != cal_pkg::ST_OK) |-> (o_item.value_out == 0))
        else $error("refused operation returned a word");

    // reset empties the result register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // an accepted item never appears as a result in the next cycle
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("result appeared too early");

endmodule

bind cursor_array_list_core cal_checker u_cal_checker (.*);
